[design/vrp_pkg.sv]
package vrp_pkg;

  typedef enum logic [2:0] {
    REG_COS     = 3'd0,
    REG_SIN     = 3'd1,
    REG_PIVOT_X = 3'd2,
    REG_PIVOT_Z = 3'd3,
    REG_X_MIN   = 3'd4,
    REG_Y_MIN   = 3'd5,
    REG_X_SPAN  = 3'd6,
    REG_Y_SPAN  = 3'd7
  } vrp_reg_t;

  localparam int QUOT_W   = 48;  // |coord| << 16
  localparam int SPAN_W   = 31;
  localparam int SCR_BITS = 15;  // magnitude bits of a screen coordinate

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_z;
    logic signed [31:0] x_min;
    logic signed [31:0] y_min;
    logic [SPAN_W-1:0]  x_span;  // zero already mapped to one
    logic [SPAN_W-1:0]  y_span;
  } vrp_cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               behind;
  } vrp_item_t;

endpackage

[design/vrp_rotate.sv]
module vrp_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  vrp_pkg::vrp_cfg_t  cfg,
  input  logic               in_valid,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  output logic               out_valid,
  output vrp_pkg::vrp_item_t out_item
);
  import vrp_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic               v1, v2, v3;
  logic signed [32:0] dx, dz;
  logic signed [31:0] y1, y2;
  logic signed [48:0] pcx, psz, pcz, psx;
  logic signed [49:0] sum_x, sum_z;
  logic signed [36:0] full_x, full_z;
  logic signed [31:0] rx, rz;

  // round to q16.16: add half lsb, floor shift by 14
  assign sum_x  = 50'(pcx) + 50'(psz) + 50'sd8192;
  assign sum_z  = 50'(pcz) - 50'(psx) + 50'sd8192;
  assign full_x = 37'($signed(sum_x[49:14])) + 37'(cfg.pivot_x);
  assign full_z = 37'($signed(sum_z[49:14])) + 37'(cfg.pivot_z);
  assign rx     = sat32(full_x);
  assign rz     = sat32(full_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx              <= 33'(vx) - 33'(cfg.pivot_x);
      dz              <= 33'(vz) - 33'(cfg.pivot_z);
      y1              <= vy;
      pcx             <= 49'(cfg.cos_angle) * 49'(dx);
      psz             <= 49'(cfg.sin_angle) * 49'(dz);
      pcz             <= 49'(cfg.cos_angle) * 49'(dz);
      psx             <= 49'(cfg.sin_angle) * 49'(dx);
      y2              <= y1;
      out_item.x      <= rx;
      out_item.y      <= y2;
      out_item.z      <= rz;
      out_item.behind <= (rz[31] || rz == 32'sd0);
    end
  end

  assign out_valid = v3;

endmodule

[design/vrp_div.sv]
module vrp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  vrp_pkg::vrp_item_t          in_item,
  output logic                        out_valid,
  output vrp_pkg::vrp_item_t          out_item,
  output logic [vrp_pkg::QUOT_W-1:0]  qx_mag,
  output logic [vrp_pkg::QUOT_W-1:0]  qy_mag,
  output logic                        qx_neg,
  output logic                        qy_neg
);
  import vrp_pkg::*;

  // one quotient bit per stage, x and y share the divisor
  logic              vld [QUOT_W];
  vrp_item_t         itm [QUOT_W];
  logic [QUOT_W-1:0] nx  [QUOT_W];
  logic [QUOT_W-1:0] ny  [QUOT_W];
  logic [30:0]       rmx [QUOT_W];
  logic [30:0]       rmy [QUOT_W];
  logic [30:0]       den [QUOT_W];
  logic              sgx [QUOT_W];
  logic              sgy [QUOT_W];

  logic [31:0] mag_x0, mag_y0;

  assign mag_x0 = in_item.x[31] ? 32'(-in_item.x) : in_item.x;
  assign mag_y0 = in_item.y[31] ? 32'(-in_item.y) : in_item.y;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_st
    logic              cv, csx, csy;
    vrp_item_t         cit;
    logic [QUOT_W-1:0] cnx, cny;
    logic [30:0]       crx, cry, cd;
    logic [31:0]       tx, ty;
    logic              gx, gy;

    if (k == 0) begin : g_first
      assign cv  = in_valid;
      assign cit = in_item;
      assign cnx = {mag_x0, 16'd0};
      assign cny = {mag_y0, 16'd0};
      assign crx = '0;
      assign cry = '0;
      assign cd  = in_item.behind ? 31'd1 : in_item.z[30:0];
      assign csx = in_item.x[31];
      assign csy = in_item.y[31];
    end else begin : g_next
      assign cv  = vld[k-1];
      assign cit = itm[k-1];
      assign cnx = nx[k-1];
      assign cny = ny[k-1];
      assign crx = rmx[k-1];
      assign cry = rmy[k-1];
      assign cd  = den[k-1];
      assign csx = sgx[k-1];
      assign csy = sgy[k-1];
    end

    assign tx = {crx, cnx[QUOT_W-1]};
    assign ty = {cry, cny[QUOT_W-1]};
    assign gx = tx >= {1'b0, cd};
    assign gy = ty >= {1'b0, cd};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm[k] <= cit;
        nx[k]  <= {cnx[QUOT_W-2:0], gx};
        ny[k]  <= {cny[QUOT_W-2:0], gy};
        rmx[k] <= gx ? 31'(tx - {1'b0, cd}) : tx[30:0];
        rmy[k] <= gy ? 31'(ty - {1'b0, cd}) : ty[30:0];
        den[k] <= cd;
        sgx[k] <= csx;
        sgy[k] <= csy;
      end
    end
  end

  assign out_valid = vld[QUOT_W-1];
  assign out_item  = itm[QUOT_W-1];
  assign qx_mag    = nx[QUOT_W-1];
  assign qy_mag    = ny[QUOT_W-1];
  assign qx_neg    = sgx[QUOT_W-1];
  assign qy_neg    = sgy[QUOT_W-1];

endmodule

[design/vrp_map.sv]
module vrp_map #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 800
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  vrp_pkg::vrp_cfg_t          cfg,
  input  logic                       in_valid,
  input  vrp_pkg::vrp_item_t         in_item,
  input  logic [vrp_pkg::QUOT_W-1:0] qx_mag,
  input  logic [vrp_pkg::QUOT_W-1:0] qy_mag,
  input  logic                       qx_neg,
  input  logic                       qy_neg,
  output logic                       out_valid,
  output vrp_pkg::vrp_item_t         out_item,
  output logic signed [15:0]         out_sx,
  output logic signed [15:0]         out_sy
);
  import vrp_pkg::*;

  localparam logic signed [63:0] WMUL = 64'(SCREEN_WIDTH);
  localparam logic signed [63:0] HMUL = 64'(SCREEN_HEIGHT);

  logic               v1, v2, v3, v4;
  vrp_item_t          i1, i2, i3, i4;
  logic signed [48:0] qx, qy;
  logic signed [49:0] tx;
  logic signed [51:0] ty;
  logic signed [63:0] nx, ny;
  logic [62:0]        mx, my;
  logic               ngx3, ngy3;

  assign qx = qx_neg ? -$signed({1'b0, qx_mag}) : $signed({1'b0, qx_mag});
  assign qy = qy_neg ? -$signed({1'b0, qy_mag}) : $signed({1'b0, qy_mag});

  // stage 4 seeds the short division, stages 5..19 produce 15 quotient bits
  logic              vld [SCR_BITS+1];
  vrp_item_t         itm [SCR_BITS+1];
  logic [30:0]       rmx [SCR_BITS+1];
  logic [30:0]       rmy [SCR_BITS+1];
  logic [14:0]       lwx [SCR_BITS+1];
  logic [14:0]       lwy [SCR_BITS+1];
  logic              ovx [SCR_BITS+1];
  logic              ovy [SCR_BITS+1];
  logic              ngx [SCR_BITS+1];
  logic              ngy [SCR_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      vld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1     <= in_item;
      tx     <= 50'(qx) - 50'(cfg.x_min);
      ty     <= $signed({21'd0, cfg.y_span}) + 52'(cfg.y_min) - 52'(qy);
      i2     <= i1;
      nx     <= 64'(tx) * WMUL;
      ny     <= 64'(ty) * HMUL;
      i3     <= i2;
      ngx3   <= nx[63];
      ngy3   <= ny[63];
      mx     <= nx[63] ? 63'(-nx) : nx[62:0];
      my     <= ny[63] ? 63'(-ny) : ny[62:0];
      itm[0] <= i3;
      ngx[0] <= ngx3;
      ngy[0] <= ngy3;
      // quotient reaches 2^15 exactly when |n| >> 15 is at least the span
      ovx[0] <= mx[62:15] >= {17'd0, cfg.x_span};
      ovy[0] <= my[62:15] >= {17'd0, cfg.y_span};
      rmx[0] <= mx[45:15];
      rmy[0] <= my[45:15];
      lwx[0] <= mx[14:0];
      lwy[0] <= my[14:0];
    end
  end

  for (genvar k = 1; k <= SCR_BITS; k++) begin : g_st
    logic [31:0] tx_k, ty_k;
    logic        gx, gy;

    assign tx_k = {rmx[k-1], lwx[k-1][14]};
    assign ty_k = {rmy[k-1], lwy[k-1][14]};
    assign gx   = tx_k >= {1'b0, cfg.x_span};
    assign gy   = ty_k >= {1'b0, cfg.y_span};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm[k] <= itm[k-1];
        rmx[k] <= gx ? 31'(tx_k - {1'b0, cfg.x_span}) : tx_k[30:0];
        rmy[k] <= gy ? 31'(ty_k - {1'b0, cfg.y_span}) : ty_k[30:0];
        lwx[k] <= {lwx[k-1][13:0], gx};
        lwy[k] <= {lwy[k-1][13:0], gy};
        ovx[k] <= ovx[k-1];
        ovy[k] <= ovy[k-1];
        ngx[k] <= ngx[k-1];
        ngy[k] <= ngy[k-1];
      end
    end
  end

  logic signed [15:0] sx_fin, sy_fin;

  always_comb begin
    if (itm[SCR_BITS].behind) begin
      sx_fin = '0;
    end else if (ovx[SCR_BITS]) begin
      sx_fin = ngx[SCR_BITS] ? 16'sh8000 : 16'sh7fff;
    end else if (ngx[SCR_BITS]) begin
      sx_fin = -$signed({1'b0, lwx[SCR_BITS]});
    end else begin
      sx_fin = $signed({1'b0, lwx[SCR_BITS]});
    end
    if (itm[SCR_BITS].behind) begin
      sy_fin = '0;
    end else if (ovy[SCR_BITS]) begin
      sy_fin = ngy[SCR_BITS] ? 16'sh8000 : 16'sh7fff;
    end else if (ngy[SCR_BITS]) begin
      sy_fin = -$signed({1'b0, lwy[SCR_BITS]});
    end else begin
      sy_fin = $signed({1'b0, lwy[SCR_BITS]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vld[SCR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i4     <= itm[SCR_BITS];
      out_sx <= sx_fin;
      out_sy <= sy_fin;
    end
  end

  assign out_valid = v4;
  assign out_item  = i4;

endmodule

[design/vertex_rotate_project.sv]
// vertex rotate and project
// input channel: in_valid / in_stall with vertex_x, vertex_y, vertex_z (signed q16.16).
// output channel: out_valid / out_stall with the rotated vertex, screen_x,
// screen_y and behind_camera, one result item for every input item, in order.
// configuration: cfg_we writes cfg_data to register cfg_index (cos, sin,
// pivot x, pivot z, x min, y min, x span, y span); write only while idle.
// from input accept to output valid an item passes the rotate stages, the
// bit-per-stage divide by rotated z, the window mapping, the 15-bit divide
// by span and the output register. every stage is one pipeline register.
// throughput is one item per cycle while the output is not stalled.
// when the output stalls with a valid item the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// reset clears all valid bits and loads the default angle, pivot and window.
module vertex_rotate_project #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 800
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic signed [31:0] rotated_z,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic               behind_camera
);
  import vrp_pkg::*;

  vrp_cfg_t  cfg;
  logic      en;
  logic      rot_valid, div_valid, map_valid;
  vrp_item_t rot_item, div_item, map_item;
  logic [QUOT_W-1:0] qx_mag, qy_mag;
  logic      qx_neg, qy_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle <= 16'sd16381;
      cfg.sin_angle <= 16'sd328;
      cfg.pivot_x   <= 32'sd0;
      cfg.pivot_z   <= 32'sd196608;
      cfg.x_min     <= -32'sd19661;
      cfg.y_min     <= -32'sd19661;
      cfg.x_span    <= 31'd39322;
      cfg.y_span    <= 31'd39322;
    end else if (cfg_we) begin
      unique case (vrp_reg_t'(cfg_index))
        REG_COS:     cfg.cos_angle <= cfg_data[15:0];
        REG_SIN:     cfg.sin_angle <= cfg_data[15:0];
        REG_PIVOT_X: cfg.pivot_x   <= cfg_data;
        REG_PIVOT_Z: cfg.pivot_z   <= cfg_data;
        REG_X_MIN:   cfg.x_min     <= cfg_data;
        REG_Y_MIN:   cfg.y_min     <= cfg_data;
        // a zero span divides as one
        REG_X_SPAN:  cfg.x_span    <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
        REG_Y_SPAN:  cfg.y_span    <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign en       = !(map_valid && out_stall);
  assign in_stall = !en;

  vrp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .vx        (vertex_x),
    .vy        (vertex_y),
    .vz        (vertex_z),
    .out_valid (rot_valid),
    .out_item  (rot_item)
  );

  vrp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .in_item   (rot_item),
    .out_valid (div_valid),
    .out_item  (div_item),
    .qx_mag    (qx_mag),
    .qy_mag    (qy_mag),
    .qx_neg    (qx_neg),
    .qy_neg    (qy_neg)
  );

  vrp_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_item   (div_item),
    .qx_mag    (qx_mag),
    .qy_mag    (qy_mag),
    .qx_neg    (qx_neg),
    .qy_neg    (qy_neg),
    .out_valid (map_valid),
    .out_item  (map_item),
    .out_sx    (screen_x),
    .out_sy    (screen_y)
  );

  assign out_valid     = map_valid;
  assign rotated_x     = map_item.x;
  assign rotated_y     = map_item.y;
  assign rotated_z     = map_item.z;
  assign behind_camera = map_item.behind;

endmodule

[design/vrp_checker.sv]
module vrp_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] vertex_x,
  input logic signed [31:0] vertex_y,
  input logic signed [31:0] vertex_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] rotated_x,
  input logic signed [31:0] rotated_y,
  input logic signed [31:0] rotated_z,
  input logic signed [15:0] screen_x,
  input logic signed [15:0] screen_y,
  input logic               behind_camera
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y) && $stable(rotated_z))
    else $error("stalled output item changed");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && behind_camera |-> screen_x == 16'sd0 && screen_y == 16'sd0)
    else $error("screen not zero for vertex behind camera");

  a_front_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && !behind_camera |-> !rotated_z[31] && rotated_z != 32'sd0)
    else $error("behind_camera flag disagrees with rotated z");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output moves");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);

[tb/sv/tb_vertex_rotate_project.sv]
`timescale 1ns / 100ps

module tb_vertex_rotate_project;
  import vrp_pkg::*;

  localparam int SCR_W = 800;
  localparam int SCR_H = 800;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 300;
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               behind;
  } proj_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    proj_t              want;
  } vertex_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] vertex_x, vertex_y, vertex_z;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] rotated_x, rotated_y, rotated_z;
  logic signed [15:0] screen_x, screen_y;
  logic behind_camera;

  vertex_rotate_project #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
    .screen_x(screen_x), .screen_y(screen_y), .behind_camera(behind_camera)
  );

  // shadow copy of the register file
  logic signed [15:0] m_cos, m_sin;
  logic signed [31:0] m_piv_x, m_piv_z, m_x_min, m_y_min;
  logic [30:0] m_x_span, m_y_span;

  proj_t pending_q[$];
  int errors;
  int cycles;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vertex_rotate_project regression: fail");
      $finish;
    end
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic proj_t project_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    proj_t r;
    longint dx, dz, rx, rz, ry, xs, ys, qx, qy, nx, ny;
    dx = longint'(x) - longint'(m_piv_x);
    dz = longint'(z) - longint'(m_piv_z);
    // q.30 sum, round half up then floor shift
    rx = ((longint'(m_cos) * dx + longint'(m_sin) * dz + 8192) >>> 14) + longint'(m_piv_x);
    rz = ((longint'(m_cos) * dz - longint'(m_sin) * dx + 8192) >>> 14) + longint'(m_piv_z);
    rx = sat(rx, -64'sd2147483648, 64'sd2147483647);
    rz = sat(rz, -64'sd2147483648, 64'sd2147483647);
    ry = longint'(y);
    r.rx = rx[31:0];
    r.ry = y;
    r.rz = rz[31:0];
    r.sx = '0;
    r.sy = '0;
    r.behind = 1'b1;
    if (rz > 0) begin
      xs = (m_x_span == 0) ? 1 : longint'({33'd0, m_x_span});
      ys = (m_y_span == 0) ? 1 : longint'({33'd0, m_y_span});
      qx = (rx * 65536) / rz;
      qy = (ry * 65536) / rz;
      nx = (qx - longint'(m_x_min)) * SCR_W;
      ny = SCR_H * ys - (qy - longint'(m_y_min)) * SCR_H;
      nx = sat(nx / xs, -32768, 32767);
      ny = sat(ny / ys, -32768, 32767);
      r.sx = nx[15:0];
      r.sy = ny[15:0];
      r.behind = 1'b0;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom;
      5, 6: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic write_reg(vrp_reg_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COS:     m_cos = value[15:0];
      REG_SIN:     m_sin = value[15:0];
      REG_PIVOT_X: m_piv_x = value;
      REG_PIVOT_Z: m_piv_z = value;
      REG_X_MIN:   m_x_min = value;
      REG_Y_MIN:   m_y_min = value;
      REG_X_SPAN:  m_x_span = value[30:0];
      REG_Y_SPAN:  m_y_span = value[30:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_window(logic [15:0] c, logic [15:0] s, logic [31:0] px, logic [31:0] pz,
                             logic [31:0] xm, logic [31:0] ym, logic [31:0] xsp,
                             logic [31:0] ysp);
    // upper bits of the narrow registers are junk on purpose
    write_reg(REG_COS, {16'($urandom), c});
    write_reg(REG_SIN, {16'($urandom), s});
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Z, pz);
    write_reg(REG_X_MIN, xm);
    write_reg(REG_Y_MIN, ym);
    write_reg(REG_X_SPAN, {1'($urandom), xsp[30:0]});
    write_reg(REG_Y_SPAN, {1'($urandom), ysp[30:0]});
  endtask

  // called on a falling edge, returns on the falling edge after acceptance
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit typed, proj_t want);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? want : project_vertex(x, y, z));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int n);
    proj_t none;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
    end
    no_idle = 1'b0;
  endtask

  // output side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 9) < 3);
        hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    proj_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with no pending vertex");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (rotated_x !== e.rx) begin
          $error("rotated_x expected %0d got %0d", e.rx, rotated_x); errors++;
        end
        if (rotated_y !== e.ry) begin
          $error("rotated_y expected %0d got %0d", e.ry, rotated_y); errors++;
        end
        if (rotated_z !== e.rz) begin
          $error("rotated_z expected %0d got %0d", e.rz, rotated_z); errors++;
        end
        if (screen_x !== e.sx) begin
          $error("screen_x expected %0d got %0d", e.sx, screen_x); errors++;
        end
        if (screen_y !== e.sy) begin
          $error("screen_y expected %0d got %0d", e.sy, screen_y); errors++;
        end
        if (behind_camera !== e.behind) begin
          $error("behind_camera expected %0d got %0d", e.behind, behind_camera); errors++;
        end
      end
    end
  end

  vertex_row_t rows[$];

  initial begin
    proj_t none, origin;
    vertex_row_t row;
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COS;
    cfg_data = '0;
    in_valid = 1'b0;
    vertex_x = '0;
    vertex_y = '0;
    vertex_z = '0;
    m_cos = 16381; m_sin = 328;
    m_piv_x = 0; m_piv_z = 196608;
    m_x_min = -19661; m_y_min = -19661;
    m_x_span = 39322; m_y_span = 39322;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // origin with reset window: lands just in front of the camera, far left
    origin = '{rx: -3936, ry: 0, rz: 36, sx: -32768, sy: 400, behind: 1'b0};
    rows.push_back('{0, 0, 0, 1'b1, origin});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none});
    rows.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, none});
    rows.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0, none});
    rows.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none});
    rows.push_back('{0, 0, 32'sh80000000, 1'b0, none});             // behind camera
    rows.push_back('{0, 0, -65536, 1'b0, none});
    rows.push_back('{0, 65536, 196608, 1'b0, none});                // on the pivot
    rows.push_back('{65536, -65536, 262144, 1'b0, none});
    rows.push_back('{-65536, 65536, 327680, 1'b0, none});
    rows.push_back('{32'sh7fffffff, 0, 262144, 1'b0, none});        // screen saturation
    rows.push_back('{0, 32'sh80000000, 262144, 1'b0, none});
    rows.push_back('{1, -1, 196609, 1'b0, none});
    rows.push_back('{-1, 1, 32'sh00030001, 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_vertex(row.x, row.y, row.z, row.typed, row.want);
    end
    run_random(PHASE_ITEMS);
    wait_idle();

    // identity rotation: rotated z equals input z, zero z is behind the camera
    load_window(16384, 0, 0, 0, -65536, -65536, 131072, 131072);
    send_vertex(0, 0, 0, 1'b0, none);
    send_vertex(65536, 65536, 1, 1'b0, none);
    send_vertex(-65536, -65536, -1, 1'b0, none);
    run_random(PHASE_ITEMS);
    wait_idle();

    // extreme registers, zero spans
    load_window(16'hc000, 16384, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                0, 0);
    run_random(PHASE_ITEMS / 2);
    wait_idle();

    // out of range angles, widest and narrowest spans
    load_window(16'h8000, 16'h7fff, $urandom, $urandom, $urandom, $urandom,
                32'h7fffffff, 1);
    run_random(PHASE_ITEMS / 2);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      load_window(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                  32'($urandom_range(0, 32'h000fffff)) - 32'h00080000,
                  32'($urandom_range(0, 32'h000fffff)),
                  -32'($urandom_range(1, 32'h0001ffff)), -32'($urandom_range(1, 32'h0001ffff)),
                  $urandom_range(1, 32'h000fffff), $urandom_range(1, 32'h000fffff));
      run_random(PHASE_ITEMS);
      wait_idle();
    end

    if (errors == 0) begin
      $display("vertex_rotate_project regression: pass");
    end else begin
      $display("vertex_rotate_project regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/vrp_pkg.sv
design/vrp_rotate.sv
design/vrp_div.sv
design/vrp_map.sv
design/vertex_rotate_project.sv
design/vrp_checker.sv
tb/sv/tb_vertex_rotate_project.sv
